// File: design/qdt_pkg.sv
package qdt_pkg;

	localparam int TIMER_BITS  = 24;
	localparam int ELAPSED_W   = 24;
	localparam int BIAS_W      = 8;
	localparam int TIME_W      = 31;
	localparam int COUNT_W     = 32;
	localparam int BASE_W      = ELAPSED_W + 1;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 168;
	localparam int CFG_INDEX_W = 1;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// low TIMER_BITS of the elapsed field are used
	localparam logic [ELAPSED_W-1:0] ELAPSED_MASK = (TIMER_BITS >= ELAPSED_W) ?
		{ELAPSED_W{1'b1}} : ELAPSED_W'((64'd1 << TIMER_BITS) - 64'd1);

	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_CAPTURE = 2'd1,
		CMD_ZERO    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MICROSTEP_MODE = 1'd0,
		REG_DEBOUNCE_BIAS  = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'b00,
		STEP_UP   = 2'b01,
		STEP_DOWN = 2'b11
	} step_t;

	// code = {b_new, a_new, b_old, a_old}
	function automatic step_t step_dir(input logic [3:0] code);
		step_t dir;
		unique case (code)
			4'd1, 4'd7, 4'd8, 4'd14:  dir = STEP_UP;
			4'd2, 4'd4, 4'd11, 4'd13: dir = STEP_DOWN;
			default:                  dir = STEP_NONE;
		endcase
		return dir;
	endfunction

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

endpackage

// File: design/qdt_timing.sv
module qdt_timing (
	input  logic                             microstep_mode,
	input  logic [qdt_pkg::BASE_W-1:0]       base,
	input  logic [qdt_pkg::TIME_W-1:0]       between_time,
	input  logic [qdt_pkg::TIME_W-1:0]       time_sum,
	output logic [qdt_pkg::TIME_W-1:0]       step_time,
	output logic [qdt_pkg::TIME_W-1:0]       between_acc,
	output logic [qdt_pkg::TIME_W-1:0]       time_sum_acc
);

	logic [qdt_pkg::TIME_W-1:0] base_w;

	assign base_w       = qdt_pkg::TIME_W'(base);
	// time since the last counted edge, held at the ceiling
	assign between_acc  = qdt_pkg::sat_add(base_w, between_time);
	assign step_time    = microstep_mode ? base_w : between_acc;
	assign time_sum_acc = qdt_pkg::sat_add(time_sum, step_time);

endmodule

// File: design/quadrature_decoder_with_timing_core.sv
// Requests pass through the input register and then the result register.
// Throughput: one request per cycle unless the output stalls; one result per request.
// State (count, offsets, interval, time sums) updates in the cycle a request leaves the
// input register, so consecutive requests see each other's effect without bubbles.
// Reset (arst_n low, asynchronous): all state and the result valid flag cleared,
// microstep_mode = 1, debounce_bias = 49.
module quadrature_decoder_with_timing_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [0] pin_a, [1] pin_b, [25:2] elapsed, [31:26] zero
	input  logic [qdt_pkg::IN_DATA_W-1:0]         s_axis_tdata,
	// [1:0] command
	input  logic [1:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [31:0] position, [33:32] step, [65:34] last_interval, [97:66] capture_count,
	// [129:98] count_delta, [160:130] captured_time, [161] time_saturated, [167:162] zero
	output logic [qdt_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	input  logic                                  cfg_we,
	input  logic [qdt_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [qdt_pkg::BIAS_W-1:0]            cfg_data
);

	localparam int TW = qdt_pkg::TIME_W;
	localparam int CW = qdt_pkg::COUNT_W;

	// configuration
	logic                          microstep_mode_q;
	logic [qdt_pkg::BIAS_W-1:0]    debounce_bias_q;

	// input stage
	logic                          valid_s1;
	qdt_pkg::cmd_t                 cmd_s1;
	logic [1:0]                    levels_s1;
	logic [qdt_pkg::BASE_W-1:0]    base_s1;

	// decoder state
	logic [1:0]                    prev_levels_q;
	logic [CW-1:0]                 raw_count_q;
	logic [CW-1:0]                 zero_offset_q;
	logic [CW-1:0]                 count_at_capture_q;
	logic [TW-1:0]                 time_sum_q;
	logic [TW-1:0]                 between_q;
	logic [CW-1:0]                 interval_q;

	// result register
	logic                          out_valid_q;
	logic [qdt_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                          advance;
	logic                          in_accept;
	logic [qdt_pkg::ELAPSED_W-1:0] elapsed_m;

	logic [TW-1:0]                 step_time;
	logic [TW-1:0]                 between_acc;
	logic [TW-1:0]                 time_sum_acc;

	qdt_pkg::step_t                dir;
	logic [1:0]                    prev_levels_d;
	logic [CW-1:0]                 raw_count_d;
	logic [CW-1:0]                 zero_offset_d;
	logic [CW-1:0]                 count_at_capture_d;
	logic [TW-1:0]                 time_sum_d;
	logic [TW-1:0]                 between_d;
	logic [CW-1:0]                 interval_d;
	qdt_pkg::step_t                step_out;
	logic [CW-1:0]                 cap_count;
	logic [CW-1:0]                 cap_change;
	logic [TW-1:0]                 cap_time;
	logic                          cap_sat;
	logic [CW-1:0]                 position;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign elapsed_m     = s_axis_tdata[25:2] & qdt_pkg::ELAPSED_MASK;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			microstep_mode_q <= 1'b1;
			debounce_bias_q  <= qdt_pkg::BIAS_W'(49);
		end else if (cfg_we) begin
			unique case (qdt_pkg::cfg_reg_t'(cfg_index))
				qdt_pkg::REG_MICROSTEP_MODE: microstep_mode_q <= cfg_data[0];
				qdt_pkg::REG_DEBOUNCE_BIAS:  debounce_bias_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// the user must keep bias static while requests are in flight (not enforced here), so fold it in on entry
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1    <= qdt_pkg::cmd_t'(s_axis_tuser);
			levels_s1 <= {s_axis_tdata[1], s_axis_tdata[0]};
			base_s1   <= {1'b0, elapsed_m} + qdt_pkg::BASE_W'(debounce_bias_q);
		end
	end

	qdt_timing u_timing (
		.microstep_mode (microstep_mode_q),
		.base           (base_s1),
		.between_time   (between_q),
		.time_sum       (time_sum_q),
		.step_time      (step_time),
		.between_acc    (between_acc),
		.time_sum_acc   (time_sum_acc)
	);

	assign dir = qdt_pkg::step_dir({levels_s1, prev_levels_q});

	always_comb begin
		prev_levels_d      = prev_levels_q;
		raw_count_d        = raw_count_q;
		zero_offset_d      = zero_offset_q;
		count_at_capture_d = count_at_capture_q;
		time_sum_d         = time_sum_q;
		between_d          = between_q;
		interval_d         = interval_q;
		step_out           = qdt_pkg::STEP_NONE;
		cap_count          = '0;
		cap_change         = '0;
		cap_time           = '0;
		cap_sat            = 1'b0;
		unique case (cmd_s1)
			qdt_pkg::CMD_SAMPLE: begin
				prev_levels_d = levels_s1;
				if (!microstep_mode_q) begin
					between_d = between_acc;
				end
				if (dir != qdt_pkg::STEP_NONE) begin
					step_out   = dir;
					between_d  = '0;
					time_sum_d = time_sum_acc;
					if (dir == qdt_pkg::STEP_UP) begin
						raw_count_d = raw_count_q + CW'(1);
						interval_d  = {1'b0, step_time};
					end else begin
						raw_count_d = raw_count_q - CW'(1);
						interval_d  = CW'(0) - {1'b0, step_time};
					end
				end
			end
			qdt_pkg::CMD_CAPTURE: begin
				cap_count          = raw_count_q;
				cap_change         = raw_count_q - count_at_capture_q;
				count_at_capture_d = raw_count_q;
				cap_time           = time_sum_q;
				cap_sat            = (time_sum_q == qdt_pkg::TIME_MAX);
				time_sum_d         = '0;
			end
			qdt_pkg::CMD_ZERO: begin
				zero_offset_d = raw_count_q;
			end
			default: ;
		endcase
		position = raw_count_d - zero_offset_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q      <= '0;
			raw_count_q        <= '0;
			zero_offset_q      <= '0;
			count_at_capture_q <= '0;
			time_sum_q         <= '0;
			between_q          <= '0;
			interval_q         <= '0;
		end else if (advance) begin
			prev_levels_q      <= prev_levels_d;
			raw_count_q        <= raw_count_d;
			zero_offset_q      <= zero_offset_d;
			count_at_capture_q <= count_at_capture_d;
			time_sum_q         <= time_sum_d;
			between_q          <= between_d;
			interval_q         <= interval_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {6'b0, cap_sat, cap_time, cap_change, cap_count,
				interval_d, step_out, position};
		end
	end

endmodule
